[sv/rigid_body_rotation_rk4_step_top_defines.svh]
// Assertion macros for the checker module.
`ifndef RIGID_BODY_ROTATION_RK4_STEP_TOP_DEFINES_SVH
`define RIGID_BODY_ROTATION_RK4_STEP_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RBR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbr check failed");

// Next-cycle implication, disabled during reset.
`define RBR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbr check failed");

`endif

[sv/rbr_pkg.sv]
`default_nettype none
package rbr_pkg;

	localparam int unsigned RATE_WIDTH_DEF = 32;
	localparam int unsigned FIELD_W        = 32;
	localparam int unsigned TIME_W         = 48;
	localparam int unsigned STEP_W         = 25;
	localparam logic [STEP_W-1:0] H_ONE    = 25'h100_0000;
	localparam int unsigned KSUM_W         = 36;
	// 6 * 2^31: lifts the weighted k sum to non-negative before dividing
	localparam logic [KSUM_W-1:0] DIV_BIAS = 36'h3_0000_0000;
	localparam int unsigned DIV_W          = 40;
	localparam int unsigned MUL_W          = 33;
	localparam int unsigned PROD_W         = 66;
	localparam int unsigned PC_W           = 5;

	// Register indexes
	typedef enum logic [2:0] {
		REG_ACCEL_X    = 3'd0,
		REG_ACCEL_Y    = 3'd1,
		REG_ACCEL_Z    = 3'd2,
		REG_COUPLING_X = 3'd3,
		REG_COUPLING_Y = 3'd4,
		REG_COUPLING_Z = 3'd5,
		REG_STEP_SIZE  = 3'd6
	} reg_idx_t;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	// Microcode operations
	typedef enum logic [3:0] {
		UC_MUL_AB   = 4'd0,
		UC_MUL_CP   = 4'd1,
		UC_MUL_HD   = 4'd2,
		UC_KEEP     = 4'd3,
		UC_BR_LAST  = 4'd4,
		UC_PT_UPD   = 4'd5,
		UC_DIV_LOAD = 4'd6,
		UC_DIV_STEP = 4'd7,
		UC_FINAL    = 4'd8
	} uc_op_t;

	typedef struct packed {
		uc_op_t          op;
		logic [1:0]      axis;
		logic [PC_W-1:0] target;
	} uc_word_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] val;
		logic                      hit;
	} sat_t;

	// Control store: one RK4 stage is 12 words plus branch and point update
	function automatic uc_word_t ucode(logic [PC_W-1:0] pc);
		uc_word_t w;
		w = '{op: UC_FINAL, axis: AX_X, target: '0};
		case (pc)
			5'd0:  w = '{op: UC_MUL_AB,   axis: AX_X, target: '0};
			5'd1:  w = '{op: UC_MUL_CP,   axis: AX_X, target: '0};
			5'd2:  w = '{op: UC_MUL_HD,   axis: AX_X, target: '0};
			5'd3:  w = '{op: UC_KEEP,     axis: AX_X, target: '0};
			5'd4:  w = '{op: UC_MUL_AB,   axis: AX_Y, target: '0};
			5'd5:  w = '{op: UC_MUL_CP,   axis: AX_Y, target: '0};
			5'd6:  w = '{op: UC_MUL_HD,   axis: AX_Y, target: '0};
			5'd7:  w = '{op: UC_KEEP,     axis: AX_Y, target: '0};
			5'd8:  w = '{op: UC_MUL_AB,   axis: AX_Z, target: '0};
			5'd9:  w = '{op: UC_MUL_CP,   axis: AX_Z, target: '0};
			5'd10: w = '{op: UC_MUL_HD,   axis: AX_Z, target: '0};
			5'd11: w = '{op: UC_KEEP,     axis: AX_Z, target: '0};
			5'd12: w = '{op: UC_BR_LAST,  axis: AX_X, target: 5'd14};
			5'd13: w = '{op: UC_PT_UPD,   axis: AX_X, target: 5'd0};
			5'd14: w = '{op: UC_DIV_LOAD, axis: AX_X, target: '0};
			5'd15: w = '{op: UC_DIV_STEP, axis: AX_X, target: '0};
			5'd16: w = '{op: UC_DIV_STEP, axis: AX_X, target: '0};
			5'd17: w = '{op: UC_DIV_STEP, axis: AX_X, target: '0};
			5'd18: w = '{op: UC_DIV_STEP, axis: AX_X, target: '0};
			5'd19: w = '{op: UC_DIV_STEP, axis: AX_X, target: '0};
			default: w = '{op: UC_FINAL,  axis: AX_X, target: '0};
		endcase
		return w;
	endfunction

	// Saturate to a signed rw-bit range, flag when clipped
	function automatic sat_t sat_rw(logic signed [47:0] v, int unsigned rw);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		sat_t r;
		hi = (48'sd1 <<< (rw - 1)) - 48'sd1;
		lo = -hi - 48'sd1;
		if (v > hi) begin
			r.val = FIELD_W'(hi);
			r.hit = 1'b1;
		end else if (v < lo) begin
			r.val = FIELD_W'(lo);
			r.hit = 1'b1;
		end else begin
			r.val = FIELD_W'(v);
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[sv/rbr_mul.sv]
`default_nettype none
// Shared signed multiplier with registered product
module rbr_mul (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire logic signed [rbr_pkg::MUL_W-1:0]      a,
	input  wire logic signed [rbr_pkg::MUL_W-1:0]      b,
	output logic signed [rbr_pkg::PROD_W-1:0]          prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= rbr_pkg::PROD_W'(a) * rbr_pkg::PROD_W'(b);
		end
	end

endmodule
`default_nettype wire

[sv/rbr_div3.sv]
`default_nettype none
// Three lanes of divide-by-three, one byte (four radix-4 digits) per step
module rbr_div3 (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire rbr_pkg::div_ctl_t               ctl,
	input  wire logic [rbr_pkg::DIV_W-1:0]       num [3],
	output logic [rbr_pkg::DIV_W-1:0]            quo [3]
);

	logic [rbr_pkg::DIV_W-1:0] num_q [3];
	logic [rbr_pkg::DIV_W-1:0] quo_q [3];
	logic [1:0]                rem_q [3];
	logic [7:0]                qbyte [3];
	logic [1:0]                rem_d [3];

	// Digit recurrence on the top byte of each lane
	always_comb begin
		logic [1:0] r;
		logic [3:0] v;
		logic [1:0] qd;
		for (int n = 0; n < 3; n++) begin
			r = rem_q[n];
			qbyte[n] = '0;
			for (int d = 0; d < 4; d++) begin
				v = {r, num_q[n][rbr_pkg::DIV_W-1-2*d -: 2]};
				if (v >= 4'd9)
					qd = 2'd3;
				else if (v >= 4'd6)
					qd = 2'd2;
				else if (v >= 4'd3)
					qd = 2'd1;
				else
					qd = 2'd0;
				r = 2'(v - 4'(qd) * 4'd3);
				qbyte[n][7-2*d -: 2] = qd;
			end
			rem_d[n] = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 3; n++) begin
				num_q[n] <= '0;
				quo_q[n] <= '0;
				rem_q[n] <= '0;
			end
		end else if (ctl.load) begin
			for (int n = 0; n < 3; n++) begin
				num_q[n] <= num[n];
				quo_q[n] <= '0;
				rem_q[n] <= '0;
			end
		end else if (ctl.step) begin
			for (int n = 0; n < 3; n++) begin
				num_q[n] <= {num_q[n][rbr_pkg::DIV_W-9:0], 8'd0};
				quo_q[n] <= {quo_q[n][rbr_pkg::DIV_W-9:0], qbyte[n]};
				rem_q[n] <= rem_d[n];
			end
		end
	end

	assign quo = quo_q;

endmodule
`default_nettype wire

[sv/rigid_body_rotation_rk4_step_top.sv]
`default_nettype none
// Rigid-body rate integrator: a load transaction (tuser 0) sets the three rates and
// clears elapsed time; a step transaction (tuser 1) runs one RK4 step of Euler's
// rotation equations as a sequence of microcode words. The step time is set by the
// twelve derivative evaluations, each three dependent products through the one
// shared multiplier, and by a five-step divide-by-three for the 1/6 weight.
// One transaction is worked at a time; the result register lets the next
// transaction be taken while a result waits. Registers must be written by wr_en
// only while idle; the block does not enforce this. Indexes above 6 are ignored.
module rigid_body_rotation_rk4_step_top #(
	parameter int unsigned RATE_WIDTH = rbr_pkg::RATE_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [2:0]   wr_index,
	input  wire logic [31:0]  wr_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// load_rate_x, load_rate_y, load_rate_z
	input  wire logic [95:0]  s_axis_tdata,
	// func
	input  wire logic [0:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// rate_x, rate_y, rate_z, elapsed_time
	output logic [143:0]      m_axis_tdata,
	// saturated
	output logic [0:0]        m_axis_tuser
);

	localparam int unsigned RW = (RATE_WIDTH > 32) ? 32 : ((RATE_WIDTH < 16) ? 16 : RATE_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                                 state_q;
	logic [rbr_pkg::PC_W-1:0]               pc_q;
	logic [1:0]                             stage_q;
	logic                                   sat_q;
	logic signed [31:0]                     acc_q [3];
	logic signed [31:0]                     coup_q [3];
	logic [rbr_pkg::STEP_W-1:0]             h_q;
	logic signed [RW-1:0]                   rate_q [3];
	logic signed [RW-1:0]                   pt_q [3];
	logic signed [31:0]                     kst_q [3];
	logic signed [rbr_pkg::KSUM_W-1:0]      ksum_q [3];
	logic [rbr_pkg::TIME_W-1:0]             time_q;
	logic [rbr_pkg::TIME_W-1:0]             shown_q;
	logic [143:0]                           out_data_q;
	logic                                   out_sat_q;
	logic                                   out_valid_q;

	rbr_pkg::uc_word_t                      cw;
	logic [rbr_pkg::STEP_W-1:0]             h_c;
	logic signed [31:0]                     oa, ob, acc_sel, coup_sel;
	logic signed [rbr_pkg::MUL_W-1:0]       mul_a, mul_b;
	logic                                   mul_en;
	logic signed [rbr_pkg::PROD_W-1:0]      prod_q;
	rbr_pkg::sat_t                          sh_sat, d_sat;
	logic signed [31:0]                     k_now;
	rbr_pkg::sat_t                          pt_sat [3];
	rbr_pkg::sat_t                          fin_sat [3];
	rbr_pkg::sat_t                          ld_sat [3];
	logic [rbr_pkg::DIV_W-1:0]              div_num [3];
	logic [rbr_pkg::DIV_W-1:0]              div_quo [3];
	rbr_pkg::div_ctl_t                      div_ctl;
	logic                                   step_hit;
	logic                                   in_acc, out_free;

	assign cw  = rbr_pkg::ucode(pc_q);
	assign h_c = (h_q > rbr_pkg::H_ONE) ? rbr_pkg::H_ONE : h_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Operand selection for the current axis
	always_comb begin
		case (cw.axis)
			rbr_pkg::AX_X: begin
				oa = 32'(pt_q[1]); ob = 32'(pt_q[2]);
				acc_sel = acc_q[0]; coup_sel = coup_q[0];
			end
			rbr_pkg::AX_Y: begin
				oa = 32'(pt_q[0]); ob = 32'(pt_q[2]);
				acc_sel = acc_q[1]; coup_sel = coup_q[1];
			end
			default: begin
				oa = 32'(pt_q[0]); ob = 32'(pt_q[1]);
				acc_sel = acc_q[2]; coup_sel = coup_q[2];
			end
		endcase
	end

	// Product post-processing
	assign sh_sat = rbr_pkg::sat_rw(signed'(prod_q[63:16]), RW);
	assign d_sat  = rbr_pkg::sat_rw(48'(acc_sel) - 48'(sh_sat.val), RW);
	assign k_now  = signed'(prod_q[55:24]);

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b0;
		case (cw.op)
			rbr_pkg::UC_MUL_AB: begin
				mul_a = 33'(oa); mul_b = 33'(ob); mul_en = 1'b1;
			end
			rbr_pkg::UC_MUL_CP: begin
				mul_a = 33'(coup_sel); mul_b = 33'(sh_sat.val); mul_en = 1'b1;
			end
			rbr_pkg::UC_MUL_HD: begin
				mul_a = signed'({8'd0, h_c}); mul_b = 33'(d_sat.val); mul_en = 1'b1;
			end
			default: ;
		endcase
	end

	rbr_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// Per-lane stage points, final sums and divider operands
	always_comb begin
		logic signed [32:0] inc;
		logic [rbr_pkg::KSUM_W-1:0] u;
		for (int n = 0; n < 3; n++) begin
			inc = (stage_q < 2'd2) ? 33'(kst_q[n] >>> 1) : 33'(kst_q[n]);
			pt_sat[n] = rbr_pkg::sat_rw(48'(rate_q[n]) + 48'(inc), RW);
			fin_sat[n] = rbr_pkg::sat_rw(48'(rate_q[n]) + signed'({15'd0, div_quo[n][32:0]})
				- 48'sd2147483648, RW);
			ld_sat[n] = rbr_pkg::sat_rw(48'(signed'(s_axis_tdata[32*n +: 32])), RW);
			u = ksum_q[n] + rbr_pkg::DIV_BIAS;
			div_num[n] = {6'd0, u[34:1]};
		end
	end

	assign div_ctl.load = (state_q == ST_RUN) && (cw.op == rbr_pkg::UC_DIV_LOAD);
	assign div_ctl.step = (state_q == ST_RUN) && (cw.op == rbr_pkg::UC_DIV_STEP);

	rbr_div3 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.quo    (div_quo)
	);

	// Saturation seen by the current word
	always_comb begin
		case (cw.op)
			rbr_pkg::UC_MUL_CP: step_hit = sh_sat.hit;
			rbr_pkg::UC_MUL_HD: step_hit = sh_sat.hit | d_sat.hit;
			rbr_pkg::UC_PT_UPD: step_hit = pt_sat[0].hit | pt_sat[1].hit | pt_sat[2].hit;
			rbr_pkg::UC_FINAL:  step_hit = fin_sat[0].hit | fin_sat[1].hit | fin_sat[2].hit;
			default:            step_hit = 1'b0;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 3; n++) begin
				acc_q[n]  <= '0;
				coup_q[n] <= '0;
			end
			h_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				rbr_pkg::REG_ACCEL_X:    acc_q[0]  <= signed'(wr_data);
				rbr_pkg::REG_ACCEL_Y:    acc_q[1]  <= signed'(wr_data);
				rbr_pkg::REG_ACCEL_Z:    acc_q[2]  <= signed'(wr_data);
				rbr_pkg::REG_COUPLING_X: coup_q[0] <= signed'(wr_data);
				rbr_pkg::REG_COUPLING_Y: coup_q[1] <= signed'(wr_data);
				rbr_pkg::REG_COUPLING_Z: coup_q[2] <= signed'(wr_data);
				rbr_pkg::REG_STEP_SIZE:  h_q       <= wr_data[rbr_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and datapath state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			stage_q     <= '0;
			sat_q       <= 1'b0;
			time_q      <= '0;
			shown_q     <= '0;
			out_valid_q <= 1'b0;
			for (int n = 0; n < 3; n++) begin
				rate_q[n] <= '0;
				pt_q[n]   <= '0;
				kst_q[n]  <= '0;
				ksum_q[n] <= '0;
			end
		end else begin
			// Result valid: set on hand-off, cleared when taken
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!s_axis_tuser[0]) begin
							for (int n = 0; n < 3; n++)
								rate_q[n] <= ld_sat[n].val[RW-1:0];
							sat_q   <= ld_sat[0].hit | ld_sat[1].hit | ld_sat[2].hit;
							time_q  <= '0;
							shown_q <= '0;
							state_q <= ST_DONE;
						end else begin
							for (int n = 0; n < 3; n++) begin
								pt_q[n]   <= rate_q[n];
								ksum_q[n] <= '0;
							end
							sat_q   <= 1'b0;
							stage_q <= '0;
							pc_q    <= '0;
							shown_q <= time_q;
							time_q  <= time_q + rbr_pkg::TIME_W'(h_c);
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					sat_q <= sat_q | step_hit;
					// Jump on the last-stage branch and on a point update
					if ((cw.op == rbr_pkg::UC_BR_LAST && stage_q == 2'd3) ||
						cw.op == rbr_pkg::UC_PT_UPD)
						pc_q <= cw.target;
					else
						pc_q <= pc_q + 1'b1;
					case (cw.op)
						rbr_pkg::UC_KEEP: begin
							for (int n = 0; n < 3; n++) begin
								if (cw.axis == 2'(n)) begin
									kst_q[n] <= k_now;
									ksum_q[n] <= ksum_q[n] + ((stage_q == 2'd1 || stage_q == 2'd2)
										? (36'(k_now) <<< 1) : 36'(k_now));
								end
							end
						end
						rbr_pkg::UC_PT_UPD: begin
							for (int n = 0; n < 3; n++)
								pt_q[n] <= pt_sat[n].val[RW-1:0];
							stage_q <= stage_q + 1'b1;
						end
						rbr_pkg::UC_FINAL: begin
							for (int n = 0; n < 3; n++)
								rate_q[n] <= fin_sat[n].val[RW-1:0];
							state_q <= ST_DONE;
						end
						default: ;
					endcase
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {shown_q, 32'(rate_q[2]), 32'(rate_q[1]), 32'(rate_q[0])};
			out_sat_q  <= sat_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_sat_q;

endmodule
`default_nettype wire

[sv/rbr_checker.sv]
`default_nettype none
`include "rigid_body_rotation_rk4_step_top_defines.svh"
// Port-level checks on the integrator
module rbr_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic [0:0]   s_axis_tuser,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [143:0] m_axis_tdata,
	input wire logic [0:0]   m_axis_tuser
);

	logic in_acc, out_free;
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	// A stalled result holds
	`RBR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	// One transaction at a time: busy right after taking one
	`RBR_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready)
	// A step gives no early result
	`RBR_ASSERT_NEXT(a_step_not_early, in_acc && s_axis_tuser[0] && out_free, !m_axis_tvalid)
	// A load is answered with zero elapsed time
	`RBR_ASSERT_NEXT(a_load_result, in_acc && !s_axis_tuser[0] && out_free,
		##1 (m_axis_tvalid && m_axis_tdata[143:96] == 48'd0))

endmodule

bind rigid_body_rotation_rk4_step_top rbr_checker u_rbr_checker (.*);
`default_nettype wire
